@@ rtl/nmea_wind_sentence_parser_unit_defines.svh @@
// ----------------------------------------------------------------------------
// NMEA wind sentence parser - assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef NMEA_WIND_SENTENCE_PARSER_UNIT_DEFINES_SVH
`define NMEA_WIND_SENTENCE_PARSER_UNIT_DEFINES_SVH

// same-cycle implication
`define NWSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nwsp assertion failed: %m");

// next-cycle implication
`define NWSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nwsp assertion failed: %m");

`endif

@@ rtl/nwsp_pkg.sv @@
// ----------------------------------------------------------------------------
// NMEA wind sentence parser - package
// Character constants and the classified character item.
// ----------------------------------------------------------------------------
package nwsp_pkg;

	// hundredths; range 0..3
	localparam int FRACTION_DIGITS = 2;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_W      = 8'h57;
	localparam logic [7:0] CH_V      = 8'h56;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_NUL    = 8'h00;

	typedef struct packed {
		logic [7:0] ch;
		logic [3:0] digit;
		logic       is_digit;
		logic       is_dot;
		logic       is_space;
		logic       is_comma;
		logic       is_star;
		logic       is_nul;
	} nwsp_item_t;

endpackage

@@ rtl/nwsp_front.sv @@
// ----------------------------------------------------------------------------
// NMEA wind sentence parser - front stage
// Accepts received characters and registers them with their class flags.
// ----------------------------------------------------------------------------
module nwsp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	output logic                item_valid,
	input  logic                item_ready,
	output nwsp_pkg::nwsp_item_t item
);
	import nwsp_pkg::*;

	nwsp_item_t cls;
	nwsp_item_t item_s1;
	logic       valid_s1;

	always_comb begin
		cls          = '0;
		cls.ch       = s_tdata;
		cls.digit    = s_tdata[3:0];
		cls.is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
		cls.is_dot   = (s_tdata == CH_DOT);
		cls.is_space = (s_tdata == CH_SPACE) || ((s_tdata >= CH_TAB) && (s_tdata <= CH_CR));
		cls.is_comma = (s_tdata == CH_COMMA);
		cls.is_star  = (s_tdata == CH_STAR);
		cls.is_nul   = (s_tdata == CH_NUL);
	end

	assign s_tready = !valid_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= cls;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

@@ rtl/nwsp_queue.sv @@
// ----------------------------------------------------------------------------
// NMEA wind sentence parser - item queue
// Small FIFO of classified characters between front and back.
// ----------------------------------------------------------------------------
module nwsp_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	output logic                wr_ready,
	input  nwsp_pkg::nwsp_item_t wr_item,
	output logic                rd_valid,
	input  logic                rd_ready,
	output nwsp_pkg::nwsp_item_t rd_item
);
	import nwsp_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	nwsp_item_t      mem [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_item  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/nwsp_back.sv @@
// ----------------------------------------------------------------------------
// NMEA wind sentence parser - back end
// Header match, payload field parser and the result register.
// ----------------------------------------------------------------------------
module nwsp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  nwsp_pkg::nwsp_item_t item,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [39:0]         m_tdata,
	output logic [1:0]          m_tuser
);
	import nwsp_pkg::*;

	localparam logic [2:0] HDR_LAST    = 3'd6;
	localparam logic [2:0] HDR_PAYLOAD = 3'd7;

	localparam logic [2:0] FLD_DIR  = 3'd0;
	localparam logic [2:0] FLD_REF  = 3'd1;
	localparam logic [2:0] FLD_SEP  = 3'd2;
	localparam logic [2:0] FLD_SPD  = 3'd3;
	localparam logic [2:0] FLD_DONE = 3'd4;
	localparam logic [2:0] FLD_FAIL = 3'd5;

	function automatic logic [7:0] header_char(input logic [2:0] pos);
		logic [7:0] r;
		unique case (pos)
			3'd0:    r = CH_DOLLAR;
			3'd1:    r = CH_I;
			3'd2:    r = CH_I;
			3'd3:    r = CH_M;
			3'd4:    r = CH_W;
			3'd5:    r = CH_V;
			3'd6:    r = CH_COMMA;
			default: r = CH_NUL;
		endcase
		return r;
	endfunction

	function automatic logic [9:0] ten_pow(input logic [1:0] e);
		logic [9:0] r;
		unique case (e)
			2'd0: r = 10'd1;
			2'd1: r = 10'd10;
			2'd2: r = 10'd100;
			2'd3: r = 10'd1000;
		endcase
		return r;
	endfunction

	logic [2:0]  hdr_q;
	logic [2:0]  fld_q;
	logic [15:0] dir_q;
	logic [15:0] spd_q;
	logic [1:0]  fds_q;
	logic        pt_q;
	logic [1:0]  seen_q;
	logic [7:0]  ref_q;

	logic [2:0]  n_hdr;
	logic [2:0]  n_fld;
	logic [15:0] n_dir;
	logic [15:0] n_spd;
	logic [1:0]  n_fds;
	logic        n_pt;
	logic [1:0]  n_seen;
	logic [7:0]  n_ref;
	logic        emit;
	logic        pop;

	// number step, shared by direction and speed
	logic [15:0] num_acc;
	logic        num_seen;
	logic [19:0] num_wide;
	logic [19:0] num_sum;
	logic [15:0] num_acc_n;
	logic        num_end;
	logic [1:0]  frac_exp;

	logic        out_valid_q;
	logic [39:0] out_data_q;
	logic [1:0]  out_user_q;

	assign num_acc  = (fld_q == FLD_SPD) ? spd_q : dir_q;
	assign num_seen = (fld_q == FLD_SPD) ? seen_q[1] : seen_q[0];
	assign num_wide = {4'd0, num_acc};
	assign frac_exp = 2'(FRACTION_DIGITS - 1 - int'(fds_q));

	always_comb begin
		if (!pt_q) begin
			num_sum = (num_wide << 3) + (num_wide << 1)
				+ 20'(item.digit) * 20'(ten_pow(2'(FRACTION_DIGITS)));
		end else if (int'(fds_q) < FRACTION_DIGITS) begin
			num_sum = num_wide + 20'(item.digit) * 20'(ten_pow(frac_exp));
		end else begin
			num_sum = num_wide;
		end
		num_acc_n = (num_sum > 20'd65535) ? 16'hFFFF : num_sum[15:0];
		num_end   = !item.is_digit && !(item.is_dot && !pt_q)
			&& !(item.is_space && !pt_q && !num_seen);
	end

	always_comb begin
		n_hdr  = hdr_q;
		n_fld  = fld_q;
		n_dir  = dir_q;
		n_spd  = spd_q;
		n_fds  = fds_q;
		n_pt   = pt_q;
		n_seen = seen_q;
		n_ref  = ref_q;
		emit   = 1'b0;
		if (hdr_q != HDR_PAYLOAD) begin
			if (item.ch == header_char(hdr_q)) begin
				n_hdr = hdr_q + 3'd1;
				if (hdr_q == HDR_LAST) begin
					n_fld  = FLD_DIR;
					n_dir  = '0;
					n_spd  = '0;
					n_fds  = '0;
					n_pt   = 1'b0;
					n_seen = '0;
					n_ref  = '0;
				end
			end
		end else if (item.is_star) begin
			emit   = 1'b1;
			n_hdr  = '0;
			n_fld  = FLD_DIR;
			n_dir  = '0;
			n_spd  = '0;
			n_fds  = '0;
			n_pt   = 1'b0;
			n_seen = '0;
			n_ref  = '0;
		end else if (!item.is_nul) begin
			unique case (fld_q)
				FLD_DIR, FLD_SPD: begin
					if (item.is_digit) begin
						if (fld_q == FLD_SPD) begin
							n_spd     = num_acc_n;
							n_seen[1] = 1'b1;
						end else begin
							n_dir     = num_acc_n;
							n_seen[0] = 1'b1;
						end
						if (pt_q && (int'(fds_q) < FRACTION_DIGITS)) begin
							n_fds = fds_q + 2'd1;
						end
					end else if (item.is_dot && !pt_q) begin
						n_pt = 1'b1;
					end else if (num_end) begin
						if (fld_q == FLD_SPD) begin
							n_fld = num_seen ? FLD_DONE : FLD_FAIL;
						end else begin
							n_fld = (num_seen && item.is_comma) ? FLD_REF : FLD_FAIL;
						end
					end
				end
				FLD_REF: begin
					n_ref = item.ch;
					n_fld = FLD_SEP;
				end
				FLD_SEP: begin
					if (item.is_comma) begin
						n_fld = FLD_SPD;
						n_pt  = 1'b0;
						n_fds = '0;
					end else begin
						n_fld = FLD_FAIL;
					end
				end
				default: begin
					n_fld = fld_q;
				end
			endcase
		end
	end

	// only a sentence end needs room in the result register
	assign item_ready = !emit || !out_valid_q || m_tready;
	assign pop        = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q  <= '0;
			fld_q  <= FLD_DIR;
			dir_q  <= '0;
			spd_q  <= '0;
			fds_q  <= '0;
			pt_q   <= 1'b0;
			seen_q <= '0;
			ref_q  <= '0;
		end else if (pop) begin
			hdr_q  <= n_hdr;
			fld_q  <= n_fld;
			dir_q  <= n_dir;
			spd_q  <= n_spd;
			fds_q  <= n_fds;
			pt_q   <= n_pt;
			seen_q <= n_seen;
			ref_q  <= n_ref;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_data_q <= {(seen_q[1] ? spd_q : 16'd0), ref_q, (seen_q[0] ? dir_q : 16'd0)};
			out_user_q <= seen_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

@@ rtl/nmea_wind_sentence_parser_unit.sv @@
// ----------------------------------------------------------------------------
// NMEA wind sentence parser unit
// Parses $IIMWV wind sentences one received character per beat and emits
// direction, reference and speed in hundredths when the '*' arrives.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                      | tuser
//  s_*     | in  | rx_char[7:0]                            | -
//  m_*     | out | wind_direction[15:0], reference_char    | direction_valid,
//          |     | [23:16], wind_speed[39:24]              | speed_valid
//
//  One character per cycle sustained unless the output stalls; the back end
//  parser retires one beat per cycle from the queue while it is not stalled.
//  The '*' passes the front register and the queue, then sets m_tvalid.
//  Reset: arst_n clears the header matcher, the payload state and all valids.
//  Output stalls back up into the queue only when a sentence end meets a
//  full result register; characters ahead of it still drain.
// ----------------------------------------------------------------------------
module nmea_wind_sentence_parser_unit #(
	parameter int QUEUE_DEPTH = 4  // 2..16 beats between front and back
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [15:0] wind_direction, [23:16] reference_char,
	                               // [39:24] wind_speed
	output logic [1:0]  m_tuser    // [0] direction_valid, [1] speed_valid
);
	import nwsp_pkg::*;

	nwsp_item_t front_item;
	nwsp_item_t back_item;
	logic       front_valid;
	logic       front_ready;
	logic       back_valid;
	logic       back_ready;

	// classify and register each incoming character
	nwsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.item_valid (front_valid),
		.item_ready (front_ready),
		.item       (front_item)
	);

	// decouples the front from result-side backpressure
	nwsp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.wr_item  (front_item),
		.rd_valid (back_valid),
		.rd_ready (back_ready),
		.rd_item  (back_item)
	);

	// header match, field parser, result register
	nwsp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (back_valid),
		.item_ready (back_ready),
		.item       (back_item),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

@@ rtl/nwsp_checker.sv @@
// ----------------------------------------------------------------------------
// NMEA wind sentence parser - port checker
// Watches both streams of the top level over time.
// ----------------------------------------------------------------------------
`include "nmea_wind_sentence_parser_unit_defines.svh"

module nwsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser
);

	logic [41:0] out_beat;

	assign out_beat = {m_tuser, m_tdata};

	`NWSP_ASSERT_NEXT(a_in_hold, clk, arst_n, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata))
	`NWSP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(out_beat))
	`NWSP_ASSERT_IMPL(a_dir_zero, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata[15:0] == 16'd0)
	`NWSP_ASSERT_IMPL(a_spd_zero, clk, arst_n, m_tvalid && !m_tuser[1], m_tdata[39:24] == 16'd0)

endmodule

bind nmea_wind_sentence_parser_unit nwsp_checker u_nwsp_checker (.*);

@@ verif/nmea_wind_report_checker.sv @@
// ----------------------------------------------------------------------------
// NMEA wind report checker
// Watches both streams of the parser. It keeps its own copy of the sentence
// parser state, predicts one wind report per '*' in the payload, and compares
// every output beat field by field with the oldest report still due.
// ----------------------------------------------------------------------------
module nmea_wind_report_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_char
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // [15:0] wind_direction, [23:16] reference_char,
	                               // [39:24] wind_speed
	input  logic [1:0]  m_tuser,   // [0] direction_valid, [1] speed_valid
	output int          failures,
	output int          reports_due_count
);
	import nwsp_pkg::*;

	typedef enum bit [2:0] {
		FIELD_DIR,
		FIELD_REF,
		FIELD_SEP,
		FIELD_SPD,
		FIELD_DONE,
		FIELD_FAIL
	} field_e;

	typedef struct packed {
		bit [15:0] direction;
		bit [7:0]  reference;
		bit [15:0] speed;
		bit        direction_ok;
		bit        speed_ok;
	} wind_report_t;

	localparam bit [2:0]  HDR_IN_PAYLOAD = 3'd7;
	// "$IIMWV," with the first character in the lowest byte
	localparam bit [55:0] SENTENCE_HEAD  =
		{CH_COMMA, CH_V, CH_W, CH_M, CH_I, CH_I, CH_DOLLAR};

	bit [2:0]     hdr_pos;
	field_e       field;
	bit [15:0]    value_acc [2];   // 0 direction, 1 speed
	bit [1:0]     frac_seen;
	bit           point_seen;
	bit [1:0]     digit_seen;      // 0 direction, 1 speed
	bit [7:0]     ref_held;
	bit [7:0]     rx;
	wind_report_t want;
	wind_report_t reports_due [$];

	function automatic int unsigned decimal_scale(input int n);
		int unsigned r;
		r = 1;
		for (int i = 0; i < n && i < 3; i++)
			r = r * 10;
		return r;
	endfunction

	function automatic void clear_payload();
		field        = FIELD_DIR;
		value_acc[0] = '0;
		value_acc[1] = '0;
		frac_seen    = '0;
		point_seen   = 1'b0;
		digit_seen   = '0;
		ref_held     = '0;
	endfunction

	// feeds one character to the number in value_acc[idx]; 1 when it ends it
	function automatic bit number_ends(input bit [7:0] c, input int idx);
		bit [31:0] v;
		bit [31:0] d;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = 32'(c - CH_ZERO);
			v = 32'(value_acc[idx]);
			if (!point_seen) begin
				v = v * 10 + d * decimal_scale(FRACTION_DIGITS);
			end else if (frac_seen < FRACTION_DIGITS) begin
				v = v + d * decimal_scale(FRACTION_DIGITS - 1 - int'(frac_seen));
				frac_seen = frac_seen + 1'b1;
			end
			value_acc[idx]  = (v > 32'd65535) ? 16'hFFFF : v[15:0];
			digit_seen[idx] = 1'b1;
			return 1'b0;
		end
		if (c == CH_DOT && !point_seen) begin
			point_seen = 1'b1;
			return 1'b0;
		end
		// leading blanks are skipped until the number starts
		if ((c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) && !point_seen && !digit_seen[idx])
			return 1'b0;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos = '0;
			clear_payload();
			reports_due.delete();
			reports_due_count = 0;
		end else begin
			// output side first: a report leaving now was predicted earlier
			if (m_tvalid && m_tready) begin
				if (reports_due.size() == 0) begin
					$error("unexpected wind report: tdata %h tuser %b", m_tdata, m_tuser);
					failures++;
				end else begin
					want = reports_due.pop_front();
					if (m_tdata[15:0] !== want.direction) begin
						$error("wind_direction: expected %0d, got %0d", want.direction,
							m_tdata[15:0]);
						failures++;
					end
					if (m_tdata[23:16] !== want.reference) begin
						$error("reference_char: expected %h, got %h", want.reference,
							m_tdata[23:16]);
						failures++;
					end
					if (m_tdata[39:24] !== want.speed) begin
						$error("wind_speed: expected %0d, got %0d", want.speed,
							m_tdata[39:24]);
						failures++;
					end
					if (m_tuser[0] !== want.direction_ok) begin
						$error("direction_valid: expected %b, got %b", want.direction_ok,
							m_tuser[0]);
						failures++;
					end
					if (m_tuser[1] !== want.speed_ok) begin
						$error("speed_valid: expected %b, got %b", want.speed_ok, m_tuser[1]);
						failures++;
					end
				end
			end

			if (s_tvalid && s_tready) begin
				rx = s_tdata;
				if (hdr_pos != HDR_IN_PAYLOAD) begin
					// a mismatch leaves the match position where it is
					if (rx == SENTENCE_HEAD[hdr_pos * 8 +: 8]) begin
						hdr_pos = hdr_pos + 1'b1;
						if (hdr_pos == HDR_IN_PAYLOAD)
							clear_payload();
					end
				end else if (rx == CH_STAR) begin
					want.direction_ok = digit_seen[0];
					want.speed_ok     = digit_seen[1];
					want.direction    = digit_seen[0] ? value_acc[0] : 16'h0;
					want.reference    = ref_held;
					want.speed        = digit_seen[1] ? value_acc[1] : 16'h0;
					reports_due.push_back(want);
					hdr_pos = '0;
					clear_payload();
				end else if (rx != CH_NUL) begin
					case (field)
						FIELD_DIR: begin
							if (number_ends(rx, 0))
								field = (digit_seen[0] && rx == CH_COMMA) ? FIELD_REF : FIELD_FAIL;
						end
						FIELD_REF: begin
							ref_held = rx;
							field    = FIELD_SEP;
						end
						FIELD_SEP: begin
							if (rx == CH_COMMA) begin
								field      = FIELD_SPD;
								point_seen = 1'b0;
								frac_seen  = '0;
							end else begin
								field = FIELD_FAIL;
							end
						end
						FIELD_SPD: begin
							if (number_ends(rx, 1))
								field = digit_seen[1] ? FIELD_DONE : FIELD_FAIL;
						end
						default: begin
						end
					endcase
				end
			end

			reports_due_count = reports_due.size();
		end
	end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// NMEA wind sentence parser testbench
// Feeds the parser character streams: a short directed opening, then mostly
// well-formed $IIMWV sentences with random numbers, blanks, NULs, bad
// separators and trailing text, mixed with raw noise. Both stream sides
// idle at random; a checker instance predicts and compares the reports.
// ----------------------------------------------------------------------------
module testbench;
	import nwsp_pkg::*;

	localparam int RANDOM_CHARS = 2000;
	// "$IIMWV," with the first character in the lowest byte
	localparam logic [55:0] SENTENCE_HEAD =
		{CH_COMMA, CH_V, CH_W, CH_M, CH_I, CH_I, CH_DOLLAR};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] rx_char
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [15:0] wind_direction, [23:16] reference_char,
	                        // [39:24] wind_speed
	logic [1:0]  m_tuser;   // [0] direction_valid, [1] speed_valid

	int          fail_count;
	int          reports_pending;
	int          chars_sent;
	bit          steady;    // no idling on either side while set
	logic [7:0]  line_buf [$];

	nmea_wind_sentence_parser_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	nmea_wind_report_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.s_tvalid          (s_tvalid),
		.s_tready          (s_tready),
		.s_tdata           (s_tdata),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.m_tdata           (m_tdata),
		.m_tuser           (m_tuser),
		.failures          (fail_count),
		.reports_due_count (reports_pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog: a run that has not finished by this time fails
	initial begin
		#10_000_000;
		$display("** nmea_wind_sentence_parser_unit: FAILED **");
		$finish;
	end

	// mostly characters that matter to the parser, else any byte
	function automatic logic [7:0] noise_char();
		case ($urandom_range(0, 11))
			0:       return CH_DOLLAR;
			1:       return CH_STAR;
			2:       return CH_COMMA;
			3:       return CH_DOT;
			4:       return CH_ZERO + 8'($urandom_range(0, 9));
			5:       return CH_SPACE;
			6:       return CH_NUL;
			7:       return CH_I;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// one beat: optional idle gap, then hold valid until it is taken
	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = (steady || $urandom_range(0, 1)) ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		chars_sent++;
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	// stop sending until every predicted report has come out
	task automatic drain_reports();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (reports_pending == 0);
		@(posedge clk);
	endtask

	// random number text: leading blanks, digits, point, fraction, maybe a NUL
	task automatic add_number();
		logic [7:0] blank;
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 2)) begin
				blank = $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13));
				line_buf.push_back(blank);
			end
		end
		// no digits now and then; up to six integer digits saturates
		if ($urandom_range(0, 9) != 0)
			repeat ($urandom_range(1, 6))
				line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
		if ($urandom_range(0, 7) == 0)
			line_buf.push_back(CH_NUL);
		if ($urandom_range(0, 1)) begin
			line_buf.push_back(CH_DOT);
			repeat ($urandom_range(0, 4))
				line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
		end
	endtask

	// receiver: random stall before each beat, none while steady
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			stall = (steady || $urandom_range(0, 1)) ? 0 : $urandom_range(0, 17);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	initial begin
		logic [7:0] c;
		int         sentences;
		int         stop_at;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		steady   = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// leading blank, saturating direction with extra fraction digits,
		// reference 0xFF, speed zero
		send_str("$IIMWV, 999.999,");
		send_char(8'hFF);
		send_str(",0*");
		// fraction-only direction, NUL ignored, wrong separator fails
		send_str("$IIMWV,.5");
		send_char(CH_NUL);
		send_str(";*");
		drain_reports();

		stop_at   = chars_sent + RANDOM_CHARS;
		sentences = 0;
		while (chars_sent < stop_at) begin
			steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) < 2) begin
				// raw noise: header fragments, stray stars, anything
				repeat ($urandom_range(1, 30)) line_buf.push_back(noise_char());
			end else begin
				// header with an occasional stray character in between
				for (int i = 0; i < 7; i++) begin
					if ($urandom_range(0, 7) == 0)
						line_buf.push_back(noise_char());
					line_buf.push_back(SENTENCE_HEAD[i * 8 +: 8]);
				end
				add_number();
				line_buf.push_back(($urandom_range(0, 9) == 0) ? noise_char() : CH_COMMA);
				case ($urandom_range(0, 3))
					0:       line_buf.push_back("R");
					1:       line_buf.push_back("T");
					default: line_buf.push_back(8'($urandom_range(0, 255)));
				endcase
				line_buf.push_back(($urandom_range(0, 9) == 0) ? noise_char() : CH_COMMA);
				add_number();
				// trailing text such as units or status, never a star
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 5)) begin
						c = noise_char();
						line_buf.push_back((c == CH_STAR) ? CH_SPACE : c);
					end
				end
				// now and then the star is lost and the text runs on
				if ($urandom_range(0, 11) != 0)
					line_buf.push_back(CH_STAR);
			end
			while (line_buf.size() != 0)
				send_char(line_buf.pop_front());
			sentences++;
			if (sentences % 15 == 0)
				drain_reports();
		end

		s_tvalid <= 1'b0;
		steady   = 1'b0;
		wait (reports_pending == 0);
		// let the clock run on so a stray late beat is still caught
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("** nmea_wind_sentence_parser_unit: PASSED **");
		end else begin
			$display("** nmea_wind_sentence_parser_unit: FAILED **");
		end
		$finish;
	end

endmodule
